// ----- rtl/sat_pkg.sv -----
// shared types and constants of the summed-area table query block
`default_nettype none

package sat_pkg;

    // field widths
    localparam int COUNT_W = 9;
    localparam int ELEM_W  = 16;
    localparam int RSUM_W  = 25;
    localparam int SUM_W   = 33;

    // default table dimensions
    localparam int DEF_MAX_ROWS = 256;
    localparam int DEF_MAX_COLS = 256;

    // reset value of both count registers
    localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

    // configuration register indexes
    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;

    // action codes of an input beat
    typedef enum logic [1:0] {
        ACT_LOAD    = 2'd0,
        ACT_QUERY   = 2'd1,
        ACT_RESTART = 2'd2
    } action_t;

    // status codes of a result beat
    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BAD_CORNERS = 2'd1,
        ST_INCOMPLETE  = 2'd2,
        ST_PAST_END    = 2'd3
    } status_t;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_QUERY,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/summed_area_table_query.sv -----
// summed-area table: row-major load, prefix store and rectangle queries
//
//  channel   | direction | handshake           | payload
//  ----------+-----------+---------------------+------------------------------------------
//  s_        | in        | s_valid / s_ready   | action, element, four 1-based corners
//  m_        | out       | m_valid / m_ready   | rect_sum (33b signed), status (2b)
//  cfg_      | in        | cfg_wr_en           | cfg_index, cfg_wdata (row/col count)
//
// a load reads the entry above, then writes the new prefix; a query reads the
// four corners through the single table port, one per cycle, then takes the last
// read's data; a restart or an error beat answers from the idle state.
// a stalled result sits in the output register; one more finished result is
// held internally and the input waits until the output register frees up.
// reset is synchronous; the table itself is not cleared, loading starts at (1,1).
`default_nettype none

module summed_area_table_query
    import sat_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // configuration writes
    input  wire logic                      cfg_wr_en,
    input  wire logic                      cfg_index,
    input  wire logic [COUNT_W-1:0]        cfg_wdata,
    // input beats
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [1:0]                s_action,
    input  wire logic signed [ELEM_W-1:0]  s_element,
    input  wire logic [COUNT_W-1:0]        s_top_row,
    input  wire logic [COUNT_W-1:0]        s_left_col,
    input  wire logic [COUNT_W-1:0]        s_bottom_row,
    input  wire logic [COUNT_W-1:0]        s_right_col,
    // result beats
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic signed [SUM_W-1:0]        m_rect_sum,
    output logic [1:0]                     m_status
);

    localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int AW    = RIW + CIW;
    localparam int DEPTH = 1 << AW;

    // table address from a 1-based row and column
    function automatic logic [AW-1:0] mk_addr(input logic [COUNT_W-1:0] row1,
                                              input logic [COUNT_W-1:0] col1);
        logic [COUNT_W-1:0] r0;
        logic [COUNT_W-1:0] c0;
        r0 = row1 - COUNT_W'(1);
        c0 = col1 - COUNT_W'(1);
        return {RIW'(r0), CIW'(c0)};
    endfunction

    // count register value as the block uses it: zero acts as one, clipped to the max
    function automatic logic [COUNT_W-1:0] clamp_cnt(input logic [COUNT_W-1:0] v,
                                                     input int lim);
        logic [COUNT_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = COUNT_W'(1);
        end else if (int'(v) > lim) begin
            res = COUNT_W'(lim);
        end
        return res;
    endfunction

    // registers
    state_t                    state_reg, state_next;
    logic [1:0]                term_reg, term_next;
    logic signed [SUM_W-1:0]   acc_reg, acc_next;
    logic [COUNT_W-1:0]        top_reg, left_reg, bot_reg, right_reg;
    logic [COUNT_W-1:0]        load_row_reg, load_row_next;
    logic [COUNT_W-1:0]        load_col_reg, load_col_next;
    logic signed [RSUM_W-1:0]  row_sum_reg, row_sum_next;
    logic                      load_done_reg, load_done_next;
    logic [COUNT_W-1:0]        rows_reg, rows_next;
    logic [COUNT_W-1:0]        cols_reg, cols_next;
    logic                      m_valid_reg, m_valid_next;
    logic signed [SUM_W-1:0]   m_sum_reg, m_sum_next;
    status_t                   m_status_reg, m_status_next;
    logic signed [SUM_W-1:0]   hold_sum_reg;
    status_t                   hold_status_reg;

    // table memory
    logic signed [SUM_W-1:0]   table_mem [DEPTH];
    logic signed [SUM_W-1:0]   rdata_reg;
    logic [AW-1:0]             mem_addr;
    logic                      mem_we;
    logic signed [SUM_W-1:0]   mem_wdata;

    // decode and result signals
    logic                      s_fire;
    logic                      out_free;
    logic                      load_ok;
    logic                      query_ok;
    logic                      res_valid;
    logic signed [SUM_W-1:0]   res_sum;
    status_t                   res_status;
    logic [COUNT_W-1:0]        cur_row1, cur_col1;
    logic [COUNT_W-1:0]        nxt_row1, nxt_col1;
    logic signed [SUM_W-1:0]   term_val;
    logic signed [SUM_W-1:0]   above_val;
    logic                      row_end;

    assign s_ready    = (state_reg == S_IDLE);
    assign s_fire     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign m_valid    = m_valid_reg;
    assign m_rect_sum = m_sum_reg;
    assign m_status   = m_status_reg;

    // load and query admission checks
    always_comb begin
        load_ok  = !load_done_reg && (load_row_reg <= rows_reg)
                   && (load_col_reg <= cols_reg);
        query_ok = load_done_reg && (s_top_row != '0) && (s_left_col != '0)
                   && (s_bottom_row <= rows_reg) && (s_right_col <= cols_reg)
                   && (s_top_row <= s_bottom_row) && (s_left_col <= s_right_col);
    end

    // corner terms: the one whose data arrives now and the one read next
    always_comb begin
        cur_row1 = (term_reg inside {2'd0, 2'd2}) ? bot_reg : top_reg - COUNT_W'(1);
        cur_col1 = (term_reg < 2'd2) ? right_reg : left_reg - COUNT_W'(1);
        nxt_row1 = (term_reg == 2'd1) ? bot_reg : top_reg - COUNT_W'(1);
        nxt_col1 = (term_reg == 2'd0) ? right_reg : left_reg - COUNT_W'(1);
        term_val = (cur_row1 != '0 && cur_col1 != '0) ? rdata_reg : '0;
        above_val = (load_row_reg != COUNT_W'(1)) ? rdata_reg : '0;
        row_end  = (load_col_reg >= cols_reg);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    if (s_action == ACT_LOAD && load_ok) begin
                        state_next = S_LOAD;
                    end else if (s_action == ACT_QUERY && query_ok) begin
                        state_next = S_QUERY;
                    end else if (!out_free) begin
                        state_next = S_DONE;
                    end
                end
            end
            S_LOAD: begin
                state_next = out_free ? S_IDLE : S_DONE;
            end
            S_QUERY: begin
                if (term_reg == 2'd3) begin
                    state_next = out_free ? S_IDLE : S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath, memory control and results
    always_comb begin
        term_next      = term_reg;
        acc_next       = acc_reg;
        load_row_next  = load_row_reg;
        load_col_next  = load_col_reg;
        row_sum_next   = row_sum_reg;
        load_done_next = load_done_reg;
        rows_next      = rows_reg;
        cols_next      = cols_reg;
        mem_addr       = '0;
        mem_we         = 1'b0;
        mem_wdata      = '0;
        res_valid      = 1'b0;
        res_sum        = '0;
        res_status     = ST_OK;

        case (state_reg)
            S_IDLE: begin
                term_next = 2'd0;
                acc_next  = '0;
                if (s_fire) begin
                    case (s_action)
                        ACT_LOAD: begin
                            if (load_ok) begin
                                // read the entry above, advance the running row sum
                                mem_addr     = mk_addr(load_row_reg - COUNT_W'(1),
                                                       load_col_reg);
                                row_sum_next = row_sum_reg + RSUM_W'(s_element);
                            end else begin
                                res_valid  = 1'b1;
                                res_status = ST_PAST_END;
                            end
                        end
                        ACT_QUERY: begin
                            if (query_ok) begin
                                mem_addr = mk_addr(s_bottom_row, s_right_col);
                            end else begin
                                res_valid  = 1'b1;
                                res_status = load_done_reg ? ST_BAD_CORNERS
                                                           : ST_INCOMPLETE;
                            end
                        end
                        ACT_RESTART: begin
                            res_valid      = 1'b1;
                            load_row_next  = COUNT_W'(1);
                            load_col_next  = COUNT_W'(1);
                            row_sum_next   = '0;
                            load_done_next = 1'b0;
                        end
                        default: begin
                            res_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_LOAD: begin
                // store the new prefix; no read this cycle, so no same-entry overlap
                mem_we    = 1'b1;
                mem_addr  = mk_addr(load_row_reg, load_col_reg);
                mem_wdata = above_val + SUM_W'(row_sum_reg);
                res_valid = 1'b1;
                res_sum   = mem_wdata;
                if (row_end) begin
                    load_col_next = COUNT_W'(1);
                    row_sum_next  = '0;
                    if (load_row_reg >= rows_reg) begin
                        load_done_next = 1'b1;
                    end else begin
                        load_row_next = load_row_reg + COUNT_W'(1);
                    end
                end else begin
                    load_col_next = load_col_reg + COUNT_W'(1);
                end
            end
            S_QUERY: begin
                // inclusion-exclusion: first and last corner add, the middle two subtract
                if (term_reg inside {2'd0, 2'd3}) begin
                    acc_next = acc_reg + term_val;
                end else begin
                    acc_next = acc_reg - term_val;
                end
                if (term_reg == 2'd3) begin
                    res_valid = 1'b1;
                    res_sum   = acc_next;
                    term_next = 2'd0;
                end else begin
                    mem_addr  = mk_addr(nxt_row1, nxt_col1);
                    term_next = term_reg + 2'd1;
                end
            end
            S_DONE: begin
                res_valid  = 1'b1;
                res_sum    = hold_sum_reg;
                res_status = hold_status_reg;
            end
            default: begin
                term_next = 2'd0;
            end
        endcase

        // a count write restarts loading
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_ROW_COUNT: rows_next = clamp_cnt(cfg_wdata, MAX_ROWS);
                REG_COL_COUNT: cols_next = clamp_cnt(cfg_wdata, MAX_COLS);
                default: begin
                    rows_next = rows_reg;
                end
            endcase
            load_row_next  = COUNT_W'(1);
            load_col_next  = COUNT_W'(1);
            row_sum_next   = '0;
            load_done_next = 1'b0;
        end
    end

    // output register
    always_comb begin
        m_valid_next  = m_valid_reg;
        m_sum_next    = m_sum_reg;
        m_status_next = m_status_reg;
        if (res_valid && out_free) begin
            m_valid_next  = 1'b1;
            m_sum_next    = res_sum;
            m_status_next = res_status;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            term_reg      <= 2'd0;
            load_row_reg  <= COUNT_W'(1);
            load_col_reg  <= COUNT_W'(1);
            row_sum_reg   <= '0;
            load_done_reg <= 1'b0;
            rows_reg      <= clamp_cnt(COUNT_RESET, MAX_ROWS);
            cols_reg      <= clamp_cnt(COUNT_RESET, MAX_COLS);
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            term_reg      <= term_next;
            load_row_reg  <= load_row_next;
            load_col_reg  <= load_col_next;
            row_sum_reg   <= row_sum_next;
            load_done_reg <= load_done_next;
            rows_reg      <= rows_next;
            cols_reg      <= cols_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        acc_reg      <= acc_next;
        m_sum_reg    <= m_sum_next;
        m_status_reg <= m_status_next;
        if (s_fire) begin
            top_reg   <= s_top_row;
            left_reg  <= s_left_col;
            bot_reg   <= s_bottom_row;
            right_reg <= s_right_col;
        end
        if (res_valid && !out_free && state_reg != S_DONE) begin
            hold_sum_reg    <= res_sum;
            hold_status_reg <= res_status;
        end
    end

    // single-port table, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            table_mem[mem_addr] <= mem_wdata;
        end else begin
            rdata_reg <= table_mem[mem_addr];
        end
    end

    // a held result implies the output register is still occupied
    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE) |-> m_valid_reg)
        else $error("held result while output register empty");

    // a finished load always leaves the column pointer at the start of a row
    a_done_col: assert property (@(posedge aclk) disable iff (!aresetn)
        load_done_reg |-> (load_col_reg == COUNT_W'(1) && row_sum_reg == '0))
        else $error("load complete with a partial row pending");

    // the term counter only moves while a query walks its corners
    a_term_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_QUERY) |-> (term_reg == 2'd0))
        else $error("term counter active outside a query");

    // a query before the load is complete answers as incomplete
    a_early_query: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_action == ACT_QUERY && !load_done_reg && !cfg_wr_en)
        |=> (state_reg == S_DONE || (m_valid && m_status == ST_INCOMPLETE)))
        else $error("early query not flagged");

endmodule

`default_nettype wire
